// ===== rtl/source_byte_lexer_defines.svh =====
// Assertion macros shared by the lexer checker.
`ifndef SOURCE_BYTE_LEXER_DEFINES_SVH
`define SOURCE_BYTE_LEXER_DEFINES_SVH
// Same-cycle implication, quiet during reset.
`define SBL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");
// Next-cycle implication, quiet during reset.
`define SBL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");
`endif

// ===== rtl/sbl_pkg.sv =====
// Shared types, token kinds, byte codes and keyword table of the lexer.
`default_nettype none
package sbl_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int LEN_BITS_DEF = 16;
    localparam int FIFO_DEPTH   = 8;
    localparam int KIND_BITS    = 6;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_NUMDOT, M_DEC, M_STRING, M_COMMENT,
        M_MINUS, M_SLASH, M_BANG, M_EQ, M_GT, M_LT, M_AMP, M_PIPE
    } mode_t;

    typedef logic [KIND_BITS-1:0] kind_t;

    localparam kind_t K_INVALID = 6'd20;
    localparam kind_t K_PLUS    = 6'd21;
    localparam kind_t K_ARROW   = 6'd22;
    localparam kind_t K_MINUS   = 6'd23;
    localparam kind_t K_STAR    = 6'd24;
    localparam kind_t K_DSLASH  = 6'd25;
    localparam kind_t K_SLASH   = 6'd26;
    localparam kind_t K_PERCENT = 6'd27;
    localparam kind_t K_COMMA   = 6'd28;
    localparam kind_t K_COLON   = 6'd29;
    localparam kind_t K_SEMI    = 6'd30;
    localparam kind_t K_DOT     = 6'd31;
    localparam kind_t K_PARL    = 6'd32;
    localparam kind_t K_PARR    = 6'd33;
    localparam kind_t K_SQL     = 6'd34;
    localparam kind_t K_SQR     = 6'd35;
    localparam kind_t K_CURL    = 6'd36;
    localparam kind_t K_CURR    = 6'd37;
    localparam kind_t K_BANGEQ  = 6'd38;
    localparam kind_t K_BANG    = 6'd39;
    localparam kind_t K_EQEQ    = 6'd40;
    localparam kind_t K_EQ      = 6'd41;
    localparam kind_t K_GE      = 6'd42;
    localparam kind_t K_GT      = 6'd43;
    localparam kind_t K_LE      = 6'd44;
    localparam kind_t K_LT      = 6'd45;
    localparam kind_t K_AND     = 6'd46;
    localparam kind_t K_OR      = 6'd47;
    localparam kind_t K_NEWLINE = 6'd48;
    localparam kind_t K_END     = 6'd49;
    localparam kind_t K_STRING  = 6'd50;
    localparam kind_t K_DECIMAL = 6'd51;
    localparam kind_t K_INTEGER = 6'd52;
    localparam kind_t K_IDENT   = 6'd53;
    localparam kind_t K_COMMENT = 6'd54;
    localparam kind_t K_MAX     = K_COMMENT;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PARL  = 8'h28;
    localparam logic [7:0] CH_PARR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SQL   = 8'h5b;
    localparam logic [7:0] CH_SQR   = 8'h5d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_CURL  = 8'h7b;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_CURR  = 8'h7d;

    // keyword text, first byte in the low bits (strings written reversed)
    localparam logic [47:0] KW_TEXT [20] = '{
        48'("tcurts"), 48'("loob"), 48'("fi"), 48'("esle"), 48'("eurt"),
        48'("eslaf"), 48'("nf"), 48'("nruter"), 48'("elihw"), 48'("rof"),
        48'("8u"), 48'("61u"), 48'("23u"), 48'("46u"), 48'("8i"),
        48'("61i"), 48'("23i"), 48'("46i"), 48'("23f"), 48'("46f")
    };
    localparam logic [2:0] KW_LEN [20] = '{
        3'd6, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd6, 3'd5, 3'd3,
        3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == CH_UNDER);
    endfunction

    // len3 is the identifier length clipped to 7
    function automatic kind_t kw_kind(input logic [47:0] prefix, input logic [2:0] len3);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < 20; i++) begin
            if ((len3 == KW_LEN[i]) && (prefix == KW_TEXT[i])) begin
                k = kind_t'(i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/source_byte_lexer.sv =====
// Top level of the byte-stream lexer: scanner front end feeding a token queue.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------------
//  input   | push / full      | ch
//  result  | pop / empty      | token_kind, start_offset, token_length, run_last
//
// One byte is taken per cycle while full is low; the scanner settles all tokens of a byte in that cycle.
// Up to three tokens per byte go into an 8-entry queue; full rises when fewer
// than three slots are free, so input stalls only when the result side lags.
// A token shows on the result ports the cycle after its byte is accepted if no token is queued ahead of it.
// Reset empties the queue and returns the scanner to idle at offset zero.
`default_nettype none
module source_byte_lexer #(
    parameter int POS_BITS = sbl_pkg::POS_BITS_DEF,
    parameter int LEN_BITS = sbl_pkg::LEN_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    ch,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [sbl_pkg::KIND_BITS-1:0]      token_kind,
    output logic [POS_BITS-1:0]                start_offset,
    output logic [LEN_BITS-1:0]                token_length,
    output logic                               run_last
);

    localparam int TW = 1 + sbl_pkg::KIND_BITS + POS_BITS + LEN_BITS;

    logic          step;
    logic [1:0]    wr_count;
    logic [TW-1:0] wr_data [3];
    logic [TW-1:0] rd_data;

    assign step = push && !full;

    sbl_front #(
        .POS_BITS (POS_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .ch       (ch),
        .wr_count (wr_count),
        .wr_data  (wr_data)
    );

    sbl_queue #(
        .TW    (TW),
        .DEPTH (sbl_pkg::FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_count (wr_count),
        .wr_data  (wr_data),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .rd_data  (rd_data)
    );

    assign {run_last, token_kind, start_offset, token_length} = rd_data;

endmodule
`default_nettype wire

// ===== rtl/sbl_front.sv =====
// Front end: scanner state machine that classifies each byte and emits up to three tokens.
`default_nettype none
module sbl_front #(
    parameter int POS_BITS = sbl_pkg::POS_BITS_DEF,
    parameter int LEN_BITS = sbl_pkg::LEN_BITS_DEF,
    localparam int TW = 1 + sbl_pkg::KIND_BITS + POS_BITS + LEN_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    ch,
    output logic [1:0]         wr_count,
    output logic [TW-1:0]      wr_data [3]
);

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);
    localparam logic [LEN_BITS-1:0] LEN_SAT = '1;

    sbl_pkg::mode_t      mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [47:0]         prefix_reg, prefix_next;

    sbl_pkg::kind_t      e_kind [3];
    logic [POS_BITS-1:0] e_off [3];
    logic [LEN_BITS-1:0] e_len [3];
    logic [1:0]          n;
    logic                used;
    logic [LEN_BITS-1:0] len_inc, len_inc2;
    logic [2:0]          len3;
    logic [7:0]          second;
    sbl_pkg::kind_t      pair_kind, single_kind;

    always_comb
    begin
        len_inc  = (len_reg == LEN_SAT) ? len_reg : len_reg + LEN_ONE;
        len_inc2 = (len_inc == LEN_SAT) ? len_inc : len_inc + LEN_ONE;
        len3     = (len_reg > LEN_BITS'(7)) ? 3'd7 : len_reg[2:0];
    end

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        pos_next    = pos_reg + POS_BITS'(1);
        used        = 1'b0;
        n           = 2'd0;
        second      = sbl_pkg::CH_NUL;
        pair_kind   = sbl_pkg::K_INVALID;
        single_kind = sbl_pkg::K_INVALID;
        for (int i = 0; i < 3; i++) begin
            e_kind[i] = sbl_pkg::K_INVALID;
            e_off[i]  = '0;
            e_len[i]  = '0;
        end

        case (mode_reg)
            sbl_pkg::M_IDENT:
            begin
                if (sbl_pkg::is_letter(ch) || sbl_pkg::is_digit(ch)) begin
                    for (int b = 0; b < 6; b++) begin
                        if (len_reg == LEN_BITS'(b)) begin
                            prefix_next[8*b +: 8] = ch;
                        end
                    end
                    len_next = len_inc;
                    used     = 1'b1;
                end else begin
                    e_kind[n] = sbl_pkg::kw_kind(prefix_reg, len3);
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_INT:
            begin
                if (sbl_pkg::is_digit(ch)) begin
                    len_next = len_inc;
                    used     = 1'b1;
                end else if (ch == sbl_pkg::CH_DOT) begin
                    mode_next = sbl_pkg::M_NUMDOT;
                    used      = 1'b1;
                end else begin
                    e_kind[n] = sbl_pkg::K_INTEGER;
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_NUMDOT:
            begin
                if (sbl_pkg::is_digit(ch)) begin
                    len_next  = len_inc2;
                    mode_next = sbl_pkg::M_DEC;
                    used      = 1'b1;
                end else begin
                    e_kind[n] = sbl_pkg::K_INTEGER;
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    e_kind[n] = sbl_pkg::K_DOT;
                    e_off[n] = pos_reg - POS_BITS'(1); e_len[n] = LEN_ONE; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_DEC:
            begin
                if (sbl_pkg::is_digit(ch)) begin
                    len_next = len_inc;
                    used     = 1'b1;
                end else begin
                    e_kind[n] = sbl_pkg::K_DECIMAL;
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_STRING:
            begin
                if (ch == sbl_pkg::CH_NUL) begin
                    e_kind[n] = sbl_pkg::K_STRING;
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end else begin
                    len_next = len_inc;
                    used     = 1'b1;
                    if (ch == sbl_pkg::CH_QUOTE) begin
                        e_kind[n] = sbl_pkg::K_STRING;
                        e_off[n] = start_reg; e_len[n] = len_inc; n = n + 2'd1;
                        mode_next = sbl_pkg::M_IDLE;
                    end
                end
            end
            sbl_pkg::M_COMMENT:
            begin
                if ((ch == sbl_pkg::CH_LF) || (ch == sbl_pkg::CH_NUL)) begin
                    e_kind[n] = sbl_pkg::K_COMMENT;
                    e_off[n] = start_reg; e_len[n] = len_reg; n = n + 2'd1;
                    mode_next = sbl_pkg::M_IDLE;
                end else begin
                    len_next = len_inc;
                    used     = 1'b1;
                end
            end
            sbl_pkg::M_MINUS:
            begin
                second = sbl_pkg::CH_GT; pair_kind = sbl_pkg::K_ARROW;
                single_kind = sbl_pkg::K_MINUS;
            end
            sbl_pkg::M_SLASH:
            begin
                second = sbl_pkg::CH_SLASH; pair_kind = sbl_pkg::K_DSLASH;
                single_kind = sbl_pkg::K_SLASH;
            end
            sbl_pkg::M_BANG:
            begin
                second = sbl_pkg::CH_EQ; pair_kind = sbl_pkg::K_BANGEQ;
                single_kind = sbl_pkg::K_BANG;
            end
            sbl_pkg::M_EQ:
            begin
                second = sbl_pkg::CH_EQ; pair_kind = sbl_pkg::K_EQEQ;
                single_kind = sbl_pkg::K_EQ;
            end
            sbl_pkg::M_GT:
            begin
                second = sbl_pkg::CH_EQ; pair_kind = sbl_pkg::K_GE;
                single_kind = sbl_pkg::K_GT;
            end
            sbl_pkg::M_LT:
            begin
                second = sbl_pkg::CH_EQ; pair_kind = sbl_pkg::K_LE;
                single_kind = sbl_pkg::K_LT;
            end
            sbl_pkg::M_AMP:
            begin
                second = sbl_pkg::CH_AMP; pair_kind = sbl_pkg::K_AND;
            end
            sbl_pkg::M_PIPE:
            begin
                second = sbl_pkg::CH_PIPE; pair_kind = sbl_pkg::K_OR;
            end
            default:
            begin
                mode_next = sbl_pkg::M_IDLE;
            end
        endcase

        // operator modes: second byte decides pair or single (invalid for a lone & or |)
        if (second != sbl_pkg::CH_NUL) begin
            if (ch == second) begin
                e_kind[n] = pair_kind;
                e_off[n] = start_reg; e_len[n] = LEN_TWO; n = n + 2'd1;
                used = 1'b1;
            end else if ((mode_reg == sbl_pkg::M_AMP) || (mode_reg == sbl_pkg::M_PIPE)) begin
                // lone & or | reports at offset zero, length zero
                e_kind[n] = sbl_pkg::K_INVALID;
                e_off[n] = '0; e_len[n] = '0; n = n + 2'd1;
            end else begin
                e_kind[n] = single_kind;
                e_off[n] = start_reg; e_len[n] = LEN_ONE; n = n + 2'd1;
            end
            mode_next = sbl_pkg::M_IDLE;
        end

        if (!used) begin
            case (ch) inside
                sbl_pkg::CH_SP, sbl_pkg::CH_TAB, sbl_pkg::CH_CR:
                begin
                end
                sbl_pkg::CH_PLUS, sbl_pkg::CH_STAR, sbl_pkg::CH_PCT, sbl_pkg::CH_COMMA,
                sbl_pkg::CH_COLON, sbl_pkg::CH_SEMI, sbl_pkg::CH_DOT, sbl_pkg::CH_PARL,
                sbl_pkg::CH_PARR, sbl_pkg::CH_SQL, sbl_pkg::CH_SQR, sbl_pkg::CH_CURL,
                sbl_pkg::CH_CURR, sbl_pkg::CH_LF:
                begin
                    case (ch)
                        sbl_pkg::CH_PLUS:  e_kind[n] = sbl_pkg::K_PLUS;
                        sbl_pkg::CH_STAR:  e_kind[n] = sbl_pkg::K_STAR;
                        sbl_pkg::CH_PCT:   e_kind[n] = sbl_pkg::K_PERCENT;
                        sbl_pkg::CH_COMMA: e_kind[n] = sbl_pkg::K_COMMA;
                        sbl_pkg::CH_COLON: e_kind[n] = sbl_pkg::K_COLON;
                        sbl_pkg::CH_SEMI:  e_kind[n] = sbl_pkg::K_SEMI;
                        sbl_pkg::CH_DOT:   e_kind[n] = sbl_pkg::K_DOT;
                        sbl_pkg::CH_PARL:  e_kind[n] = sbl_pkg::K_PARL;
                        sbl_pkg::CH_PARR:  e_kind[n] = sbl_pkg::K_PARR;
                        sbl_pkg::CH_SQL:   e_kind[n] = sbl_pkg::K_SQL;
                        sbl_pkg::CH_SQR:   e_kind[n] = sbl_pkg::K_SQR;
                        sbl_pkg::CH_CURL:  e_kind[n] = sbl_pkg::K_CURL;
                        sbl_pkg::CH_CURR:  e_kind[n] = sbl_pkg::K_CURR;
                        default:           e_kind[n] = sbl_pkg::K_NEWLINE;
                    endcase
                    e_off[n] = pos_reg; e_len[n] = LEN_ONE; n = n + 2'd1;
                end
                sbl_pkg::CH_MINUS, sbl_pkg::CH_SLASH, sbl_pkg::CH_BANG, sbl_pkg::CH_EQ,
                sbl_pkg::CH_GT, sbl_pkg::CH_LT, sbl_pkg::CH_AMP, sbl_pkg::CH_PIPE,
                sbl_pkg::CH_HASH, sbl_pkg::CH_QUOTE:
                begin
                    case (ch)
                        sbl_pkg::CH_MINUS: mode_next = sbl_pkg::M_MINUS;
                        sbl_pkg::CH_SLASH: mode_next = sbl_pkg::M_SLASH;
                        sbl_pkg::CH_BANG:  mode_next = sbl_pkg::M_BANG;
                        sbl_pkg::CH_EQ:    mode_next = sbl_pkg::M_EQ;
                        sbl_pkg::CH_GT:    mode_next = sbl_pkg::M_GT;
                        sbl_pkg::CH_LT:    mode_next = sbl_pkg::M_LT;
                        sbl_pkg::CH_AMP:   mode_next = sbl_pkg::M_AMP;
                        sbl_pkg::CH_PIPE:  mode_next = sbl_pkg::M_PIPE;
                        sbl_pkg::CH_HASH:  mode_next = sbl_pkg::M_COMMENT;
                        default:           mode_next = sbl_pkg::M_STRING;
                    endcase
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                end
                sbl_pkg::CH_NUL:
                begin
                    if (pos_reg != '0) begin
                        e_kind[n] = sbl_pkg::K_END;
                        e_off[n] = pos_reg; e_len[n] = LEN_ONE; n = n + 2'd1;
                    end
                end
                default:
                begin
                    if (sbl_pkg::is_digit(ch)) begin
                        mode_next  = sbl_pkg::M_INT;
                        start_next = pos_reg;
                        len_next   = LEN_ONE;
                    end else if (sbl_pkg::is_letter(ch)) begin
                        mode_next   = sbl_pkg::M_IDENT;
                        start_next  = pos_reg;
                        len_next    = LEN_ONE;
                        prefix_next = {40'd0, ch};
                    end else begin
                        e_kind[n] = sbl_pkg::K_INVALID;
                        e_off[n] = pos_reg; e_len[n] = LEN_ONE; n = n + 2'd1;
                    end
                end
            endcase
        end

        // end of source: back to the reset state
        if (ch == sbl_pkg::CH_NUL) begin
            mode_next   = sbl_pkg::M_IDLE;
            pos_next    = '0;
            start_next  = '0;
            len_next    = '0;
            prefix_next = '0;
        end
    end

    always_comb
    begin
        wr_count = step ? n : 2'd0;
        for (int i = 0; i < 3; i++) begin
            wr_data[i] = {(n == 2'(i + 1)), e_kind[i], e_off[i], e_len[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= sbl_pkg::M_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
        end else if (step) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sbl_queue.sv =====
// Back end: token queue taking up to three writes per cycle and delivering one item per pop.
`default_nettype none
module sbl_queue #(
    parameter int TW    = 56,
    parameter int DEPTH = sbl_pkg::FIFO_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    wr_count,
    input  wire logic [TW-1:0] wr_data [3],
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output logic [TW-1:0]      rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [TW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;
    logic          do_pop;

    assign empty   = (count_reg == '0);
    // room must exist for a worst-case burst of three
    assign full    = (count_reg > (AW + 1)'(DEPTH - 3));
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + (AW + 1)'(wr_count) - (AW + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < wr_count) begin
                mem_reg[wr_ptr_reg + AW'(i)] <= wr_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + AW'(wr_count);
            rd_ptr_reg <= rd_ptr_reg + AW'(do_pop);
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sbl_checker.sv =====
// Port-level checker for the lexer, bound to the top level.
`default_nettype none
`include "source_byte_lexer_defines.svh"
module sbl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic [5:0] token_kind,
    input wire logic       run_last
);

    // nothing appears without an accepted byte
    `SBL_ASSERT_NEXT(a_no_spurious, empty && !(push && !full), empty)
    `SBL_ASSERT_NOW(a_kind_range, !empty, token_kind <= sbl_pkg::K_MAX)
    // end token is always the final token of its byte
    `SBL_ASSERT_NOW(a_end_last, !empty && (token_kind == sbl_pkg::K_END), run_last)

endmodule

bind source_byte_lexer sbl_checker u_sbl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .token_kind (token_kind),
    .run_last   (run_last)
);
`default_nettype wire

// ===== verif/source_byte_lexer_tb.sv =====
// Self-checking testbench of the byte-stream lexer: directed and random sources.
`default_nettype none
module source_byte_lexer_tb;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] offset;
        logic [15:0] length;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  ch = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        run_last;

    source_byte_lexer DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .ch(ch),
        .pop(pop), .empty(empty), .token_kind(token_kind),
        .start_offset(start_offset), .token_length(token_length),
        .run_last(run_last)
    );

    always #5 clk = ~clk;

    // lexer state mirror
    sbl_pkg::mode_t lx_mode;
    logic [31:0] lx_pos;
    logic [31:0] lx_start;
    logic [15:0] lx_len;
    logic [47:0] lx_prefix;

    token_t      expected_tokens[$];
    token_t      step_tokens[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          stall_mode = 1'b0;
    int          burst_left = 0;

    localparam int WATCHDOG = 5000;

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alph(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] keyword_of(logic [47:0] pre, logic [15:0] len);
        string kws[20] = '{"struct", "bool", "if", "else", "true", "false", "fn",
            "return", "while", "for", "u8", "u16", "u32", "u64", "i8", "i16",
            "i32", "i64", "f32", "f64"};
        logic [47:0] packed_kw;
        for (int i = 0; i < 20; i++) begin
            packed_kw = '0;
            for (int j = 0; j < kws[i].len(); j++)
                packed_kw[8*j +: 8] = kws[i][j];
            if (len == kws[i].len() && pre == packed_kw)
                return 6'(i);
        end
        return sbl_pkg::K_IDENT;
    endfunction

    function automatic void add_token(logic [5:0] k, logic [31:0] off, logic [15:0] len);
        token_t t;
        t.kind = k;
        t.offset = off;
        t.length = len;
        t.last = 1'b0;
        if (step_tokens.size() < 3)
            step_tokens.push_back(t);
    endfunction

    function automatic void bump_len();
        if (lx_len != 16'hffff)
            lx_len = lx_len + 1;
    endfunction

    function automatic void open_tok(sbl_pkg::mode_t m, logic [31:0] p);
        lx_mode = m;
        lx_start = p;
        lx_len = 1;
    endfunction

    function automatic void lex_reset();
        lx_mode = sbl_pkg::M_IDLE;
        lx_pos = 0;
        lx_start = 0;
        lx_len = 0;
        lx_prefix = 0;
    endfunction

    function automatic void lex_fresh(logic [7:0] c, logic [31:0] p);
        case (c)
            sbl_pkg::CH_SP, sbl_pkg::CH_TAB, sbl_pkg::CH_CR: ;
            sbl_pkg::CH_PLUS:  add_token(sbl_pkg::K_PLUS, p, 1);
            sbl_pkg::CH_STAR:  add_token(sbl_pkg::K_STAR, p, 1);
            sbl_pkg::CH_PCT:   add_token(sbl_pkg::K_PERCENT, p, 1);
            sbl_pkg::CH_COMMA: add_token(sbl_pkg::K_COMMA, p, 1);
            sbl_pkg::CH_COLON: add_token(sbl_pkg::K_COLON, p, 1);
            sbl_pkg::CH_SEMI:  add_token(sbl_pkg::K_SEMI, p, 1);
            sbl_pkg::CH_DOT:   add_token(sbl_pkg::K_DOT, p, 1);
            sbl_pkg::CH_PARL:  add_token(sbl_pkg::K_PARL, p, 1);
            sbl_pkg::CH_PARR:  add_token(sbl_pkg::K_PARR, p, 1);
            sbl_pkg::CH_SQL:   add_token(sbl_pkg::K_SQL, p, 1);
            sbl_pkg::CH_SQR:   add_token(sbl_pkg::K_SQR, p, 1);
            sbl_pkg::CH_CURL:  add_token(sbl_pkg::K_CURL, p, 1);
            sbl_pkg::CH_CURR:  add_token(sbl_pkg::K_CURR, p, 1);
            sbl_pkg::CH_LF:    add_token(sbl_pkg::K_NEWLINE, p, 1);
            sbl_pkg::CH_MINUS: open_tok(sbl_pkg::M_MINUS, p);
            sbl_pkg::CH_SLASH: open_tok(sbl_pkg::M_SLASH, p);
            sbl_pkg::CH_BANG:  open_tok(sbl_pkg::M_BANG, p);
            sbl_pkg::CH_EQ:    open_tok(sbl_pkg::M_EQ, p);
            sbl_pkg::CH_GT:    open_tok(sbl_pkg::M_GT, p);
            sbl_pkg::CH_LT:    open_tok(sbl_pkg::M_LT, p);
            sbl_pkg::CH_AMP:   open_tok(sbl_pkg::M_AMP, p);
            sbl_pkg::CH_PIPE:  open_tok(sbl_pkg::M_PIPE, p);
            sbl_pkg::CH_HASH:  open_tok(sbl_pkg::M_COMMENT, p);
            sbl_pkg::CH_QUOTE: open_tok(sbl_pkg::M_STRING, p);
            sbl_pkg::CH_NUL:   if (p != 0) add_token(sbl_pkg::K_END, p, 1);
            default: begin
                if (dig(c)) open_tok(sbl_pkg::M_INT, p);
                else if (alph(c)) begin
                    open_tok(sbl_pkg::M_IDENT, p);
                    lx_prefix = {40'h0, c};
                end
                else add_token(sbl_pkg::K_INVALID, p, 1);
            end
        endcase
    endfunction

    // predicts the tokens one byte causes and queues them
    function automatic void lex_byte(logic [7:0] c);
        logic [31:0] p;
        bit used;
        logic [7:0] second;
        logic [5:0] pair, single;
        p = lx_pos;
        used = 0;
        second = 0;
        pair = 0;
        single = 0;
        step_tokens.delete();
        case (lx_mode)
            sbl_pkg::M_IDENT: begin
                if (alph(c) || dig(c)) begin
                    if (lx_len < 6) lx_prefix[8*lx_len +: 8] = c;
                    bump_len();
                    used = 1;
                end else begin
                    add_token(keyword_of(lx_prefix, lx_len), lx_start, lx_len);
                    lx_mode = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_INT: begin
                if (dig(c)) begin bump_len(); used = 1; end
                else if (c == sbl_pkg::CH_DOT) begin
                    lx_mode = sbl_pkg::M_NUMDOT;
                    used = 1;
                end else begin
                    add_token(sbl_pkg::K_INTEGER, lx_start, lx_len);
                    lx_mode = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_NUMDOT: begin
                if (dig(c)) begin
                    bump_len();
                    bump_len();
                    lx_mode = sbl_pkg::M_DEC;
                    used = 1;
                end else begin
                    add_token(sbl_pkg::K_INTEGER, lx_start, lx_len);
                    add_token(sbl_pkg::K_DOT, p - 1, 1);
                    lx_mode = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_DEC: begin
                if (dig(c)) begin bump_len(); used = 1; end
                else begin
                    add_token(sbl_pkg::K_DECIMAL, lx_start, lx_len);
                    lx_mode = sbl_pkg::M_IDLE;
                end
            end
            sbl_pkg::M_STRING: begin
                if (c == sbl_pkg::CH_NUL) begin
                    add_token(sbl_pkg::K_STRING, lx_start, lx_len);
                    lx_mode = sbl_pkg::M_IDLE;
                end else begin
                    bump_len();
                    used = 1;
                    if (c == sbl_pkg::CH_QUOTE) begin
                        add_token(sbl_pkg::K_STRING, lx_start, lx_len);
                        lx_mode = sbl_pkg::M_IDLE;
                    end
                end
            end
            sbl_pkg::M_COMMENT: begin
                if (c == sbl_pkg::CH_LF || c == sbl_pkg::CH_NUL) begin
                    add_token(sbl_pkg::K_COMMENT, lx_start, lx_len);
                    lx_mode = sbl_pkg::M_IDLE;
                end else begin
                    bump_len();
                    used = 1;
                end
            end
            sbl_pkg::M_MINUS: begin
                second = sbl_pkg::CH_GT; pair = sbl_pkg::K_ARROW; single = sbl_pkg::K_MINUS;
            end
            sbl_pkg::M_SLASH: begin
                second = sbl_pkg::CH_SLASH; pair = sbl_pkg::K_DSLASH;
                single = sbl_pkg::K_SLASH;
            end
            sbl_pkg::M_BANG: begin
                second = sbl_pkg::CH_EQ; pair = sbl_pkg::K_BANGEQ; single = sbl_pkg::K_BANG;
            end
            sbl_pkg::M_EQ: begin
                second = sbl_pkg::CH_EQ; pair = sbl_pkg::K_EQEQ; single = sbl_pkg::K_EQ;
            end
            sbl_pkg::M_GT: begin
                second = sbl_pkg::CH_EQ; pair = sbl_pkg::K_GE; single = sbl_pkg::K_GT;
            end
            sbl_pkg::M_LT: begin
                second = sbl_pkg::CH_EQ; pair = sbl_pkg::K_LE; single = sbl_pkg::K_LT;
            end
            sbl_pkg::M_AMP: begin
                second = sbl_pkg::CH_AMP; pair = sbl_pkg::K_AND; single = sbl_pkg::K_INVALID;
            end
            sbl_pkg::M_PIPE: begin
                second = sbl_pkg::CH_PIPE; pair = sbl_pkg::K_OR; single = sbl_pkg::K_INVALID;
            end
            default: lx_mode = sbl_pkg::M_IDLE;
        endcase
        if (second != 0) begin
            if (c == second) begin
                add_token(pair, lx_start, 2);
                used = 1;
            end else if (lx_mode == sbl_pkg::M_AMP || lx_mode == sbl_pkg::M_PIPE)
                add_token(sbl_pkg::K_INVALID, 0, 0);
            else
                add_token(single, lx_start, 1);
            lx_mode = sbl_pkg::M_IDLE;
        end
        if (!used) lex_fresh(c, p);
        if (c == sbl_pkg::CH_NUL) lex_reset();
        else lx_pos = p + 1;
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // sends one byte in bursts with random gaps
    task automatic send_byte(logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        push <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        lex_byte(c);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // receiver stall pattern
    always @(negedge clk) begin
        if ($urandom_range(0, 31) == 0) stall_mode = ~stall_mode;
        pop <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end

    always @(posedge clk) begin
        token_t got, want;
        if (rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (pop && !empty) begin
                got = '{token_kind, start_offset, token_length, run_last};
                if (expected_tokens.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected token %p", got);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) $display("mismatch exp %p got %p", want, got);
                    end
                end
            end
        end
    end

    task automatic test_operators();
        send_text("+*%,:;.()[]{}\n!===>=<=&&||->//! =><-/ ");
        send_byte(sbl_pkg::CH_NUL);
    endtask

    task automatic test_special_cases();
        send_byte(sbl_pkg::CH_NUL);          // empty source
        send_text("&x|y 12.x 3.25 7.");      // lone amp/pipe, integer then dot
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(sbl_pkg::CH_NUL);
        send_text("#note\n\"s\" \"op");
        send_byte(sbl_pkg::CH_NUL);
        send_text("#op");
        send_byte(sbl_pkg::CH_NUL);
    endtask

    task automatic test_keywords();
        send_text("struct return i64 structs _A9 ");
        send_byte(sbl_pkg::CH_NUL);
    endtask

    task automatic test_random_sources();
        string pieces[24] = '{"foo", "while", "u32", "123", "4.56", "9.", "\"s t\"",
            "#c\n", "->", "==", "!=", "<=", ">=", "&&", "||", "&", "|", " ", "\t",
            "\r", "\n", "(", "}", "i64"};
        string s;
        int sent;
        sent = 0;
        while (sent < 24) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                s = pieces[$urandom_range(0, 23)];
                send_text(s);
                sent += s.len();
            end
            if ($urandom_range(0, 15) == 0) begin
                send_byte(sbl_pkg::CH_NUL);
                sent++;
            end
        end
        send_byte(sbl_pkg::CH_NUL);
    endtask

    initial begin
        lex_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_operators();
        test_special_cases();
        test_keywords();
        test_random_sources();
        push <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
